[design/sbdc_pkg.sv]
// shared types and constants for the switch bank debouncer
package sbdc_pkg;

  // physical and logical pin count of the bank
  localparam int PIN_COUNT = 16;
  // fixed width of the raw pin word and the levels field
  localparam int PIN_BITS = 16;
  // remap table: one nibble per logical pin
  localparam int REMAP_BITS = 64;
  localparam logic [REMAP_BITS-1:0] REMAP_RESET = 64'hFEDC_BA98_7654_3210;

  typedef enum logic [1:0] {
    MODE_SAMPLE     = 2'd0,
    MODE_LEVEL      = 2'd1,
    MODE_CLEAR_RISE = 2'd2,
    MODE_CLEAR_FALL = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_ONE     = 2'd1,
    PH_TWO     = 2'd2,
    PH_PRESSED = 2'd3
  } phase_t;

  // per-pin control from the top level
  typedef struct packed {
    logic sample;
    logic pressed;
    logic clr_rise;
    logic clr_fall;
  } cell_ctrl_t;

  // per-pin status back to the top level
  typedef struct packed {
    logic level;
    logic rise;
    logic fall;
    logic level_nxt;
  } cell_stat_t;

endpackage

[design/sbdc_pin_cell.sv]
// one pin's debounce machine with its level, rise and fall flags
module sbdc_pin_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sbdc_pkg::cell_ctrl_t   ctrl,
  output sbdc_pkg::cell_stat_t   stat
);

  sbdc_pkg::phase_t phase_r, phase_nxt;
  logic level_r, level_nxt;
  logic rise_r, rise_nxt;
  logic fall_r, fall_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sbdc_pkg::PH_IDLE;
      level_r <= 1'b0;
      rise_r  <= 1'b0;
      fall_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      level_r <= level_nxt;
      rise_r  <= rise_nxt;
      fall_r  <= fall_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    level_nxt = level_r;
    rise_nxt  = rise_r;
    fall_nxt  = fall_r;
    if (ctrl.sample) begin
      case (phase_r)
        sbdc_pkg::PH_IDLE: begin
          fall_nxt = 1'b0;
          if (ctrl.pressed) begin
            level_nxt = 1'b0;
            rise_nxt  = 1'b0;
            phase_nxt = sbdc_pkg::PH_ONE;
          end
        end
        sbdc_pkg::PH_ONE: begin
          if (ctrl.pressed) begin
            level_nxt = 1'b0;
            rise_nxt  = 1'b0;
            phase_nxt = sbdc_pkg::PH_TWO;
          end else begin
            phase_nxt = sbdc_pkg::PH_IDLE;
          end
        end
        sbdc_pkg::PH_TWO: begin
          if (ctrl.pressed) begin
            level_nxt = 1'b1;
            rise_nxt  = 1'b1;
            phase_nxt = sbdc_pkg::PH_PRESSED;
          end else begin
            phase_nxt = sbdc_pkg::PH_IDLE;
          end
        end
        default: begin
          if (ctrl.pressed) begin
            level_nxt = 1'b1;
            rise_nxt  = 1'b0;
          end else begin
            fall_nxt  = 1'b1;
            level_nxt = 1'b0;
            rise_nxt  = 1'b0;
            phase_nxt = sbdc_pkg::PH_IDLE;
          end
        end
      endcase
    end else begin
      if (ctrl.clr_rise) begin
        rise_nxt = 1'b0;
      end
      if (ctrl.clr_fall) begin
        fall_nxt = 1'b0;
      end
    end
  end

  assign stat.level     = level_r;
  assign stat.rise      = rise_r;
  assign stat.fall      = fall_r;
  assign stat.level_nxt = level_nxt;

endmodule

[design/switch_bank_debouncer_confirm3_top.sv]
// top level of the switch bank debouncer: input stage, pin cells, query path, result register
//
// usage
//   input channel (in_valid / in_stall): one transfer per item. in_mode 0 is a
//   sample of the raw active-low pin word in_raw_pins; modes 1, 2 and 3 query
//   the logical pin in_pin for its level, or read and clear its rise or fall flag.
//   result channel (out_valid / out_stall): exactly one transfer per item,
//   carrying out_answer and out_levels, the debounced level of every pin.
//   config channel (cfg_valid / cfg_ready): writes the 64-bit remap table,
//   nibble i naming the physical pin of logical pin i. write only when idle.
// timing
//   an item is held in the input register until the result register is free or
//   being emptied, then the pin cells update and the result register loads.
//   out_valid rises as the result register loads. one item per cycle is sustained
//   while out_stall is low, as all sixteen pin cells update side by side.
// reset
//   rst_n low clears every pin machine and flag, empties both stages and loads
//   the identity remap table.
// stalls
//   while out_stall holds a result, one further item is taken into the input
//   register; after that in_stall rises until the result is transferred.
module switch_bank_debouncer_confirm3_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_mode,
  input  logic [sbdc_pkg::PIN_BITS-1:0]      in_raw_pins,
  input  logic [4:0]                         in_pin,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_answer,
  output logic [sbdc_pkg::PIN_BITS-1:0]      out_levels,
  // config channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sbdc_pkg::REMAP_BITS-1:0]    cfg_remap_table
);

  // input register
  logic                            in_valid_r, in_valid_nxt;
  sbdc_pkg::mode_t                 mode_r;
  logic [sbdc_pkg::PIN_BITS-1:0]   raw_r;
  logic [4:0]                      pin_r;

  // result register
  logic                            out_valid_r, out_valid_nxt;
  logic                            answer_r, answer_nxt;
  logic [sbdc_pkg::PIN_BITS-1:0]   levels_r, levels_nxt;

  // remap table
  logic [sbdc_pkg::REMAP_BITS-1:0] remap_r;

  logic                            in_xfer;
  logic                            advance;
  logic                            lpin_ok;
  logic [3:0]                      ppin;
  logic                            ppin_ok;
  logic                            query_hit;

  sbdc_pkg::cell_ctrl_t            ctrl   [sbdc_pkg::PIN_COUNT];
  sbdc_pkg::cell_stat_t            stat   [sbdc_pkg::PIN_COUNT];
  logic [sbdc_pkg::PIN_BITS-1:0]   level_vec, rise_vec, fall_vec;

  // the input stage moves on when the result register is free or being emptied
  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = !in_valid_r;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_xfer) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      remap_r     <= sbdc_pkg::REMAP_RESET;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        remap_r <= cfg_remap_table;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_r <= sbdc_pkg::mode_t'(in_mode);
      raw_r  <= in_raw_pins;
      pin_r  <= in_pin;
    end
    if (advance) begin
      answer_r <= answer_nxt;
      levels_r <= levels_nxt;
    end
  end

  // logical to physical pin lookup
  assign lpin_ok   = pin_r < 5'(sbdc_pkg::PIN_COUNT);
  assign ppin      = remap_r[{pin_r[3:0], 2'b00} +: 4];
  assign ppin_ok   = {1'b0, ppin} < 5'(sbdc_pkg::PIN_COUNT);
  assign query_hit = (mode_r != sbdc_pkg::MODE_SAMPLE) && lpin_ok && ppin_ok;

  // pin cells
  for (genvar p = 0; p < sbdc_pkg::PIN_COUNT; p++) begin : g_pin
    assign ctrl[p].sample   = advance && (mode_r == sbdc_pkg::MODE_SAMPLE);
    assign ctrl[p].pressed  = !raw_r[p];
    assign ctrl[p].clr_rise = advance && query_hit && (mode_r == sbdc_pkg::MODE_CLEAR_RISE)
                              && (ppin == 4'(p));
    assign ctrl[p].clr_fall = advance && query_hit && (mode_r == sbdc_pkg::MODE_CLEAR_FALL)
                              && (ppin == 4'(p));

    sbdc_pin_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl[p]),
      .stat  (stat[p])
    );
  end

  // gather status; pins beyond the bank read as zero
  always_comb begin
    level_vec  = '0;
    rise_vec   = '0;
    fall_vec   = '0;
    levels_nxt = '0;
    for (int p = 0; p < sbdc_pkg::PIN_COUNT; p++) begin
      level_vec[p]  = stat[p].level;
      rise_vec[p]   = stat[p].rise;
      fall_vec[p]   = stat[p].fall;
      levels_nxt[p] = stat[p].level_nxt;
    end
  end

  // query answer, taken from state before any clear
  always_comb begin
    answer_nxt = 1'b0;
    if (query_hit) begin
      case (mode_r)
        sbdc_pkg::MODE_LEVEL:      answer_nxt = level_vec[ppin];
        sbdc_pkg::MODE_CLEAR_RISE: answer_nxt = rise_vec[ppin];
        sbdc_pkg::MODE_CLEAR_FALL: answer_nxt = fall_vec[ppin];
        default:                   answer_nxt = 1'b0;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_answer = answer_r;
  assign out_levels = levels_r;

  // sample items always answer zero
  a_sample_answer_zero: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (mode_r == sbdc_pkg::MODE_SAMPLE) |=> !out_answer)
    else $error("sample item gave a non-zero answer");

  // out-of-range logical pins answer zero
  a_range_answer_zero: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !lpin_ok |=> !out_answer)
    else $error("out-of-range pin gave a non-zero answer");

  // input stage only holds back while a result is stuck downstream
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled with a free result register");

  // a pending rise flag implies the pin is pressed
  a_rise_implies_level: assert property (@(posedge clk) disable iff (!rst_n)
    (rise_vec & ~level_vec) == '0)
    else $error("rise flag set on a released pin");

  // a pending fall flag implies the pin is released
  a_fall_implies_release: assert property (@(posedge clk) disable iff (!rst_n)
    (fall_vec & level_vec) == '0)
    else $error("fall flag set on a pressed pin");

endmodule

[tb/testbench.sv]
// testbench for the switch bank debouncer: directed and random items against a predictor
`timescale 1ns / 1ps

module testbench;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 6;

  // one result transfer as the block should present it
  typedef struct packed {
    logic                          answer;
    logic [sbdc_pkg::PIN_BITS-1:0] levels;
  } debounce_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [1:0]                      in_mode = sbdc_pkg::MODE_SAMPLE;
  logic [sbdc_pkg::PIN_BITS-1:0]   in_raw_pins = '1;
  logic [4:0]                      in_pin = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic                            out_answer;
  logic [sbdc_pkg::PIN_BITS-1:0]   out_levels;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [sbdc_pkg::REMAP_BITS-1:0] cfg_remap_table = '0;

  // predicted block state, kept in step with accepted transfers
  sbdc_pkg::phase_t                pin_phase [sbdc_pkg::PIN_COUNT];
  logic [sbdc_pkg::PIN_BITS-1:0]   pred_level = '0;
  logic [sbdc_pkg::PIN_BITS-1:0]   pred_rise = '0;
  logic [sbdc_pkg::PIN_BITS-1:0]   pred_fall = '0;
  logic [sbdc_pkg::REMAP_BITS-1:0] pred_remap = sbdc_pkg::REMAP_RESET;

  debounce_result_t                pending_results [$];
  int                              err_count = 0;
  int                              cycle_count = 0;
  int                              snd_idle_pct = 0;
  int                              rcv_idle_pct = 0;
  // slowly changing switch word so that pins get held long enough to confirm
  logic [sbdc_pkg::PIN_BITS-1:0]   held_pins = '1;

  switch_bank_debouncer_confirm3_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_raw_pins     (in_raw_pins),
    .in_pin          (in_pin),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_answer      (out_answer),
    .out_levels      (out_levels),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_remap_table (cfg_remap_table)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    for (int p = 0; p < sbdc_pkg::PIN_COUNT; p++) pin_phase[p] = sbdc_pkg::PH_IDLE;
  end

  // advance the predicted debouncer by one item and return its result
  function automatic debounce_result_t debounce_step(sbdc_pkg::mode_t mode,
                                                     logic [sbdc_pkg::PIN_BITS-1:0] raw,
                                                     logic [4:0] lpin);
    debounce_result_t res;
    logic [3:0]       ppin;
    logic             pressed;
    res.answer = 1'b0;
    if (mode == sbdc_pkg::MODE_SAMPLE) begin
      for (int p = 0; p < sbdc_pkg::PIN_COUNT; p++) begin
        pressed = ~raw[p];
        case (pin_phase[p])
          sbdc_pkg::PH_IDLE: begin
            pred_fall[p] = 1'b0;
            if (pressed) begin
              pred_level[p] = 1'b0;
              pred_rise[p]  = 1'b0;
              pin_phase[p]  = sbdc_pkg::PH_ONE;
            end
          end
          sbdc_pkg::PH_ONE: begin
            if (pressed) begin
              pred_level[p] = 1'b0;
              pred_rise[p]  = 1'b0;
              pin_phase[p]  = sbdc_pkg::PH_TWO;
            end else begin
              pin_phase[p] = sbdc_pkg::PH_IDLE;
            end
          end
          sbdc_pkg::PH_TWO: begin
            if (pressed) begin
              // third pressed sample in a row confirms the press
              pred_level[p] = 1'b1;
              pred_rise[p]  = 1'b1;
              pin_phase[p]  = sbdc_pkg::PH_PRESSED;
            end else begin
              pin_phase[p] = sbdc_pkg::PH_IDLE;
            end
          end
          default: begin
            if (pressed) begin
              pred_level[p] = 1'b1;
              pred_rise[p]  = 1'b0;
            end else begin
              // release drops the level at once
              pred_fall[p]  = 1'b1;
              pred_level[p] = 1'b0;
              pred_rise[p]  = 1'b0;
              pin_phase[p]  = sbdc_pkg::PH_IDLE;
            end
          end
        endcase
      end
    end else if (lpin < sbdc_pkg::PIN_COUNT) begin
      ppin = pred_remap[4*lpin +: 4];
      if (ppin < sbdc_pkg::PIN_COUNT) begin
        case (mode)
          sbdc_pkg::MODE_LEVEL: res.answer = pred_level[ppin];
          sbdc_pkg::MODE_CLEAR_RISE: begin
            res.answer      = pred_rise[ppin];
            pred_rise[ppin] = 1'b0;
          end
          default: begin
            res.answer      = pred_fall[ppin];
            pred_fall[ppin] = 1'b0;
          end
        endcase
      end
    end
    res.levels = pred_level;
    return res;
  endfunction

  // result side: random stall, and a check of every result transfer
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rcv_idle_pct);
  end

  always @(posedge clk) begin
    debounce_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transfer answer=%0b levels=%h",
                 $time, out_answer, out_levels);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_answer !== want.answer) begin
          $display("%0t: answer mismatch expected=%0b actual=%0b",
                   $time, want.answer, out_answer);
          err_count++;
        end
        if (out_levels !== want.levels) begin
          $display("%0t: levels mismatch expected=%h actual=%h",
                   $time, want.levels, out_levels);
          err_count++;
        end
      end
    end
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // offer one item, hold it until the transfer, then predict its result
  task automatic send_item(sbdc_pkg::mode_t mode, logic [sbdc_pkg::PIN_BITS-1:0] raw,
                           logic [4:0] lpin);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < snd_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= mode;
    in_raw_pins <= raw;
    in_pin      <= lpin;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(debounce_step(mode, raw, lpin));
  endtask

  // stop sending and let every outstanding result arrive
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // remap table write, only with the block idle
  task automatic write_remap(logic [sbdc_pkg::REMAP_BITS-1:0] table_val);
    wait_drained();
    cfg_valid       <= 1'b1;
    cfg_remap_table <= table_val;
    do @(posedge clk); while (!cfg_ready);
    pred_remap = table_val;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_item(sbdc_pkg::MODE_LEVEL, 16'h0000, 5'd0);
    send_item(sbdc_pkg::MODE_CLEAR_RISE, 16'hFFFF, 5'd15);
    send_item(sbdc_pkg::MODE_CLEAR_FALL, 16'h5A5A, 5'd7);
    send_item(sbdc_pkg::MODE_SAMPLE, 16'hFFFF, 5'd0);
  endtask

  // all pins through a confirmed press, flag reads, then a release
  task automatic test_press_release();
    repeat (3) send_item(sbdc_pkg::MODE_SAMPLE, 16'h0000, 5'd0);
    send_item(sbdc_pkg::MODE_CLEAR_RISE, 16'hFFFF, 5'd15);
    send_item(sbdc_pkg::MODE_CLEAR_RISE, 16'hFFFF, 5'd15);
    send_item(sbdc_pkg::MODE_LEVEL, 16'hFFFF, 5'd5);
    // held press clears the rise flag on its own
    send_item(sbdc_pkg::MODE_SAMPLE, 16'h0000, 5'd0);
    send_item(sbdc_pkg::MODE_CLEAR_RISE, 16'h0000, 5'd1);
    send_item(sbdc_pkg::MODE_SAMPLE, 16'hFFFF, 5'd0);
    send_item(sbdc_pkg::MODE_CLEAR_FALL, 16'hFFFF, 5'd3);
    send_item(sbdc_pkg::MODE_CLEAR_FALL, 16'hFFFF, 5'd3);
    // next sample clears the remaining fall flags
    send_item(sbdc_pkg::MODE_SAMPLE, 16'hFFFF, 5'd31);
    send_item(sbdc_pkg::MODE_CLEAR_FALL, 16'hFFFF, 5'd4);
  endtask

  // two pressed samples then a bounce never confirm
  task automatic test_bounce();
    send_item(sbdc_pkg::MODE_SAMPLE, 16'hFFFE, 5'd0);
    send_item(sbdc_pkg::MODE_SAMPLE, 16'hFFFE, 5'd0);
    send_item(sbdc_pkg::MODE_SAMPLE, 16'hFFFF, 5'd0);
    send_item(sbdc_pkg::MODE_SAMPLE, 16'hFFFE, 5'd0);
    send_item(sbdc_pkg::MODE_LEVEL, 16'hFFFF, 5'd0);
  endtask

  task automatic test_pin_out_of_range();
    send_item(sbdc_pkg::MODE_LEVEL, 16'hFFFF, 5'd16);
    send_item(sbdc_pkg::MODE_CLEAR_RISE, 16'hFFFF, 5'd31);
    send_item(sbdc_pkg::MODE_CLEAR_FALL, 16'hFFFF, 5'd20);
  endtask

  // every logical pin onto pin 0, then every logical pin onto pin 15
  task automatic test_remap_extremes();
    write_remap(64'h0);
    repeat (3) send_item(sbdc_pkg::MODE_SAMPLE, 16'h7FFE, 5'd0);
    send_item(sbdc_pkg::MODE_CLEAR_RISE, 16'hFFFF, 5'd9);
    write_remap(64'hFFFF_FFFF_FFFF_FFFF);
    send_item(sbdc_pkg::MODE_LEVEL, 16'hFFFF, 5'd3);
    send_item(sbdc_pkg::MODE_CLEAR_RISE, 16'hFFFF, 5'd0);
  endtask

  // mostly held switch words with occasional toggles, mixed with queries
  task automatic test_random(int snd_pct, int rcv_pct, int n_items);
    logic [sbdc_pkg::PIN_BITS-1:0] raw;
    logic [4:0]                    lpin;
    sbdc_pkg::mode_t               mode;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) wait_drained();
      raw  = sbdc_pkg::PIN_BITS'($urandom);
      lpin = ($urandom_range(99) < 85) ? 5'($urandom_range(15)) : 5'($urandom_range(31, 16));
      if ($urandom_range(99) < 55) begin
        mode = sbdc_pkg::MODE_SAMPLE;
        if ($urandom_range(7) == 0) begin
          held_pins ^= sbdc_pkg::PIN_BITS'(1) << $urandom_range(15);
        end
        if ($urandom_range(39) == 0) held_pins = sbdc_pkg::PIN_BITS'($urandom);
        if ($urandom_range(4) != 0) raw = held_pins;
      end else begin
        mode = sbdc_pkg::mode_t'($urandom_range(3, 1));
      end
      send_item(mode, raw, lpin);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_remap(sbdc_pkg::REMAP_RESET);
    test_reset_state();
    test_press_release();
    test_bounce();
    test_pin_out_of_range();
    test_remap_extremes();

    write_remap({$urandom, $urandom});
    test_random(11, 70, 200);
    write_remap(64'h0123_4567_89AB_CDEF);
    test_random(70, 11, 200);
    write_remap({$urandom, $urandom});
    test_random(0, 0, 200);

    wait_drained();
    rcv_idle_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
